FILE: rtl/stun_map_pkg.sv
package stun_map_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_datagram;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        is_ipv6;
        logic [15:0] mapped_port;
        logic [63:0] address_high;
        logic [63:0] address_low;
    } t_out_item;

    localparam logic [1:0] STATUS_FOUND       = 2'd0;
    localparam logic [1:0] STATUS_NOT_SUCCESS = 2'd1;
    localparam logic [1:0] STATUS_NO_ADDRESS  = 2'd2;

    localparam logic [15:0] TYPE_BINDING_SUCCESS = 16'h0101;
    localparam logic [15:0] ATTR_MAPPED          = 16'h0001;
    localparam logic [15:0] ATTR_XOR_MAPPED      = 16'h0020;
    localparam logic [15:0] ATTR_XOR_MAPPED_ALT  = 16'h8020;
    localparam logic [7:0]  FAMILY_V4            = 8'h01;
    localparam logic [15:0] PORT_KEY             = 16'h2112;
    localparam logic [31:0] MAGIC_COOKIE         = 32'h2112A442;

    localparam int unsigned POS_W = 17;
    localparam logic [POS_W-1:0] POS_MAX       = 17'h1FFFF;
    localparam logic [POS_W-1:0] POS_ATTR_BASE = 17'd20;

endpackage

FILE: rtl/stun_map_parser.sv
module stun_map_parser (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  stun_map_pkg::t_in_item i_item,
    output logic                   o_result_valid,
    output stun_map_pkg::t_out_item o_result
);
    import stun_map_pkg::*;

    function automatic logic f_is_xor(input logic [15:0] t);
        return (t == ATTR_XOR_MAPPED) || (t == ATTR_XOR_MAPPED_ALT);
    endfunction

    function automatic logic f_is_addr(input logic [15:0] t);
        return (t == ATTR_MAPPED) || f_is_xor(t);
    endfunction

    logic [POS_W-1:0] r_pos, n_pos;
    logic [15:0]      r_msg_type, n_msg_type;
    logic [15:0]      r_body_len, n_body_len;
    logic [63:0]      r_cookie_hi, n_cookie_hi;
    logic [63:0]      r_cookie_lo, n_cookie_lo;
    logic [POS_W-1:0] r_attr_start, n_attr_start;
    logic [15:0]      r_attr_type, n_attr_type;
    logic [15:0]      r_attr_len, n_attr_len;
    logic [63:0]      r_addr_hi, n_addr_hi;
    logic [63:0]      r_addr_lo, n_addr_lo;
    logic [15:0]      r_port, n_port;
    logic             r_family, n_family;
    logic             r_found, n_found;
    logic             r_walk_done, n_walk_done;

    logic [7:0]       w_byte;
    logic [POS_W-1:0] w_msg_end;
    logic [POS_W-1:0] w_padded;
    logic [POS_W:0]   w_next_sum;
    logic [POS_W-1:0] w_next_start;
    logic [POS_W-1:0] w_start;
    logic [POS_W-1:0] w_offset;
    logic [15:0]      w_type_full;
    logic             w_hit;
    logic             w_xored;
    logic             w_fam;

    always_comb begin
        w_byte       = i_item.data_byte;
        w_msg_end    = {1'b0, r_body_len} + POS_ATTR_BASE;
        w_padded     = ({1'b0, r_attr_len} + 17'd3) & ~17'd3;
        w_next_sum   = {1'b0, r_attr_start} + 18'd4 + {1'b0, w_padded};
        w_next_start = (w_next_sum > {1'b0, POS_MAX}) ? POS_MAX : w_next_sum[POS_W-1:0];
        w_start      = r_attr_start;
        // advance to the next attribute once its header position is reached
        if (!r_walk_done && ((r_pos - r_attr_start) >= 17'd4) && (r_pos == w_next_start)) begin
            w_start = w_next_start;
        end
        w_offset    = r_pos - w_start;
        w_type_full = r_attr_type | {8'h00, w_byte};
        w_hit       = f_is_addr(r_attr_type);
        w_xored     = f_is_xor(r_attr_type);
        w_fam       = (w_byte != FAMILY_V4);

        n_pos        = r_pos;
        n_msg_type   = r_msg_type;
        n_body_len   = r_body_len;
        n_cookie_hi  = r_cookie_hi;
        n_cookie_lo  = r_cookie_lo;
        n_attr_start = r_attr_start;
        n_attr_type  = r_attr_type;
        n_attr_len   = r_attr_len;
        n_addr_hi    = r_addr_hi;
        n_addr_lo    = r_addr_lo;
        n_port       = r_port;
        n_family     = r_family;
        n_found      = r_found;
        n_walk_done  = r_walk_done;

        if (i_valid) begin
            priority if (r_pos == 17'd0) begin
                n_msg_type = {w_byte, 8'h00};
            end else if (r_pos == 17'd1) begin
                n_msg_type = r_msg_type | {8'h00, w_byte};
            end else if (r_pos == 17'd2) begin
                n_body_len = {w_byte, 8'h00};
            end else if (r_pos == 17'd3) begin
                n_body_len = r_body_len | {8'h00, w_byte};
            end else if (r_pos < 17'd12) begin
                for (int j = 0; j < 8; j++) begin
                    if (r_pos == 17'(4 + j)) begin
                        n_cookie_hi[63-8*j -: 8] = r_cookie_hi[63-8*j -: 8] | w_byte;
                    end
                end
            end else if (r_pos < POS_ATTR_BASE) begin
                for (int j = 0; j < 8; j++) begin
                    if (r_pos == 17'(12 + j)) begin
                        n_cookie_lo[63-8*j -: 8] = r_cookie_lo[63-8*j -: 8] | w_byte;
                    end
                end
            end else if ((r_pos < w_msg_end) && (r_pos >= r_attr_start)) begin
                n_attr_start = w_start;
                priority if (w_offset == 17'd0) begin
                    n_attr_type = {w_byte, 8'h00};
                    n_attr_len  = 16'h0000;
                end else if (w_offset == 17'd1) begin
                    n_attr_type = w_type_full;
                    if (f_is_addr(w_type_full)) begin
                        n_found  = 1'b1;
                        n_family = 1'b1;
                        if (f_is_xor(w_type_full)) begin
                            n_walk_done = 1'b1;
                            n_port      = PORT_KEY;
                            n_addr_hi   = r_cookie_hi;
                            n_addr_lo   = r_cookie_lo;
                        end else begin
                            n_port    = 16'h0000;
                            n_addr_hi = 64'h0;
                            n_addr_lo = 64'h0;
                        end
                    end
                end else if (w_offset == 17'd2) begin
                    n_attr_len = {w_byte, 8'h00};
                end else if (w_offset == 17'd3) begin
                    n_attr_len = r_attr_len | {8'h00, w_byte};
                end else if (w_hit && ((w_offset - 17'd4) < {1'b0, r_attr_len})) begin
                    priority if (w_offset == 17'd5) begin
                        n_family  = w_fam;
                        n_addr_hi = (w_xored && w_fam) ? r_cookie_hi : 64'h0;
                        if (!w_xored) begin
                            n_addr_lo = 64'h0;
                        end else if (w_fam) begin
                            n_addr_lo = r_cookie_lo;
                        end else begin
                            n_addr_lo = {32'h0, MAGIC_COOKIE};
                        end
                    end else if (w_offset == 17'd6) begin
                        n_port = r_port ^ {w_byte, 8'h00};
                    end else if (w_offset == 17'd7) begin
                        n_port = r_port ^ {8'h00, w_byte};
                    end else begin
                        // address bytes: IPv4 uses four, IPv6 sixteen
                        for (int j = 0; j < 4; j++) begin
                            if (!r_family && (w_offset == 17'(8 + j))) begin
                                n_addr_lo[31-8*j -: 8] = r_addr_lo[31-8*j -: 8] ^ w_byte;
                            end
                        end
                        for (int j = 0; j < 8; j++) begin
                            if (r_family && (w_offset == 17'(8 + j))) begin
                                n_addr_hi[63-8*j -: 8] = r_addr_hi[63-8*j -: 8] ^ w_byte;
                            end
                            if (r_family && (w_offset == 17'(16 + j))) begin
                                n_addr_lo[63-8*j -: 8] = r_addr_lo[63-8*j -: 8] ^ w_byte;
                            end
                        end
                    end
                end else begin
                    // drop value bytes of other attributes and padding
                end
            end else begin
                // drop bytes past the end of the message
            end

            if (r_pos != POS_MAX) begin
                n_pos = r_pos + 17'd1;
            end
        end

        o_result_valid = i_valid && i_item.end_of_datagram;
        o_result       = '0;
        if (n_msg_type != TYPE_BINDING_SUCCESS) begin
            o_result.status = STATUS_NOT_SUCCESS;
        end else if (!n_found) begin
            o_result.status = STATUS_NO_ADDRESS;
        end else begin
            o_result.status       = STATUS_FOUND;
            o_result.is_ipv6      = n_family;
            o_result.mapped_port  = n_port;
            o_result.address_high = n_family ? n_addr_hi : 64'h0;
            o_result.address_low  = n_family ? n_addr_lo : {32'h0, n_addr_lo[31:0]};
        end

        // start over for the next datagram
        if (o_result_valid) begin
            n_pos        = '0;
            n_msg_type   = '0;
            n_body_len   = '0;
            n_cookie_hi  = '0;
            n_cookie_lo  = '0;
            n_attr_start = POS_ATTR_BASE;
            n_attr_type  = '0;
            n_attr_len   = '0;
            n_addr_hi    = '0;
            n_addr_lo    = '0;
            n_port       = '0;
            n_family     = 1'b0;
            n_found      = 1'b0;
            n_walk_done  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_msg_type   <= '0;
            r_body_len   <= '0;
            r_cookie_hi  <= '0;
            r_cookie_lo  <= '0;
            r_attr_start <= POS_ATTR_BASE;
            r_attr_type  <= '0;
            r_attr_len   <= '0;
            r_addr_hi    <= '0;
            r_addr_lo    <= '0;
            r_port       <= '0;
            r_family     <= 1'b0;
            r_found      <= 1'b0;
            r_walk_done  <= 1'b0;
        end else begin
            r_pos        <= n_pos;
            r_msg_type   <= n_msg_type;
            r_body_len   <= n_body_len;
            r_cookie_hi  <= n_cookie_hi;
            r_cookie_lo  <= n_cookie_lo;
            r_attr_start <= n_attr_start;
            r_attr_type  <= n_attr_type;
            r_attr_len   <= n_attr_len;
            r_addr_hi    <= n_addr_hi;
            r_addr_lo    <= n_addr_lo;
            r_port       <= n_port;
            r_family     <= n_family;
            r_found      <= n_found;
            r_walk_done  <= n_walk_done;
        end
    end

endmodule

FILE: rtl/stun_map_out_q.sv
module stun_map_out_q (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  stun_map_pkg::t_out_item i_data,
    output logic                    o_full,
    output logic                    o_valid,
    input  logic                    i_ready,
    output stun_map_pkg::t_out_item o_data
);
    import stun_map_pkg::*;

    t_out_item  r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       w_pop;

    always_comb begin
        o_full   = (r_count == 2'd2);
        o_valid  = (r_count != 2'd0);
        o_data   = r_mem[r_rd_ptr];
        w_pop    = o_valid && i_ready;
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, i_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

FILE: rtl/stun_mapped_address_parser_core.sv
// STUN binding response parser: pulls the mapped address out of a received message.
// Input channel (i_in_valid / o_in_ready / i_in_data): one message byte per transfer,
// most significant byte first, end_of_datagram set on the final byte of the datagram.
// Output channel (o_out_valid / i_out_ready / o_out_data): one result per datagram,
// sent for the end_of_datagram byte: status, family, port and address.
// Throughput: one byte per cycle, sustained, as long as results are taken.
// Result path: a byte is held in the input register; when the final byte is consumed,
// the parser forms the result from its state and that byte and pushes it into a
// two-entry output queue, from which the receiver takes it.
// The parser state update for a byte is combinational; the byte-to-byte state
// dependency through that update sets the one-byte-per-cycle rate.
// When the receiver stalls, results wait in the queue; once it is full, a final byte
// is held in the input register and o_in_ready drops. Ordinary bytes keep flowing.
// Reset (synchronous, active low) empties both stages and returns the parser to the
// start of a datagram. After each result the parser also starts a new datagram.
module stun_mapped_address_parser_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  stun_map_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output stun_map_pkg::t_out_item o_out_data
);
    import stun_map_pkg::*;

    logic      r_in_valid, n_in_valid;
    t_in_item  r_in;
    logic      w_consume;
    logic      w_accept;
    logic      w_push;
    logic      w_full;
    t_out_item w_result;

    always_comb begin
        // hold a final byte while the result queue has no room
        w_consume  = r_in_valid && (!r_in.end_of_datagram || !w_full);
        o_in_ready = !r_in_valid || w_consume;
        w_accept   = i_in_valid && o_in_ready;
        n_in_valid = w_accept || (r_in_valid && !w_consume);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_data;
        end
    end

    stun_map_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_consume),
        .i_item         (r_in),
        .o_result_valid (w_push),
        .o_result       (w_result)
    );

    stun_map_out_q u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_result),
        .o_full  (w_full),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full))
        else $error("result pushed into a full output queue");

    a_result_from_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_push))
        else $error("output valid rose without a parsed final byte");

    a_final_byte_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in.end_of_datagram && w_full) |=> r_in_valid)
        else $error("final byte dropped while the output queue was full");

endmodule

FILE: test/tb_stun_mapped_address_parser_core.sv
module tb_stun_mapped_address_parser_core;
    import stun_map_pkg::*;

    localparam int unsigned STALL_LIMIT = 2000;

    typedef struct packed {
        logic [7:0] data;
        logic [4:0] count;
        logic       last;
        t_out_item  want;
    } t_stim_row;

    localparam t_out_item NO_WANT          = '0;
    localparam t_out_item WANT_NOT_SUCCESS = '{STATUS_NOT_SUCCESS, 1'b0, 16'h0, 64'h0, 64'h0};
    localparam t_out_item WANT_NO_ADDRESS  = '{STATUS_NO_ADDRESS, 1'b0, 16'h0, 64'h0, 64'h0};
    // zero-length XOR attribute: every address byte reads back as the key
    localparam t_out_item WANT_XOR_KEY_V6  =
        '{STATUS_FOUND, 1'b1, PORT_KEY, {64{1'b1}}, {64{1'b1}}};

    localparam t_stim_row DIRECTED [10] = '{
        '{8'hFF, 5'd1,  1'b1, WANT_NOT_SUCCESS},
        '{8'h01, 5'd1,  1'b0, NO_WANT},
        '{8'h01, 5'd1,  1'b1, WANT_NO_ADDRESS},
        '{8'h00, 5'd1,  1'b1, WANT_NOT_SUCCESS},
        '{8'h01, 5'd2,  1'b0, NO_WANT},
        '{8'h00, 5'd1,  1'b0, NO_WANT},
        '{8'h04, 5'd1,  1'b0, NO_WANT},
        '{8'hFF, 5'd16, 1'b0, NO_WANT},
        '{8'h80, 5'd1,  1'b0, NO_WANT},
        '{8'h20, 5'd1,  1'b1, WANT_XOR_KEY_V6}
    };

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_data;

    // typed expectation travels with the byte that closes a directed datagram
    logic      row_typed = 1'b0;
    t_out_item row_want  = '0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned idle_cycles   = 0;
    int unsigned bad_results   = 0;

    t_out_item  due_results[$];
    logic [7:0] dgram_q[$];

    // parser state mirror
    logic [16:0] p_pos;
    logic [16:0] p_attr_base;
    logic [15:0] p_type;
    logic [15:0] p_body_len;
    logic [15:0] p_attr_type;
    logic [15:0] p_attr_len;
    logic [15:0] p_port;
    logic [63:0] p_hdr[2];
    logic [63:0] p_addr[2];
    logic        p_v6;
    logic        p_found;
    logic        p_walk_done;

    stun_mapped_address_parser_core i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bit is_xor_attr(logic [15:0] t);
        return t == ATTR_XOR_MAPPED || t == ATTR_XOR_MAPPED_ALT;
    endfunction

    function automatic bit is_addr_attr(logic [15:0] t);
        return t == ATTR_MAPPED || is_xor_attr(t);
    endfunction

    task automatic parser_clear();
        p_pos       = '0;
        p_attr_base = POS_ATTR_BASE;
        p_type      = '0;
        p_body_len  = '0;
        p_attr_type = '0;
        p_attr_len  = '0;
        p_port      = '0;
        p_hdr[0]    = '0;
        p_hdr[1]    = '0;
        p_addr[0]   = '0;
        p_addr[1]   = '0;
        p_v6        = 1'b0;
        p_found     = 1'b0;
        p_walk_done = 1'b0;
    endtask

    // seed the address with the XOR key (zero for a plain attribute) so that absent bytes read back as the key
    task automatic load_address_key(input bit xored, input bit v6);
        if (!xored) begin
            p_addr[0] = '0;
            p_addr[1] = '0;
        end else if (v6) begin
            p_addr[0] = p_hdr[0];
            p_addr[1] = p_hdr[1];
        end else begin
            p_addr[0] = '0;
            p_addr[1] = {32'h0, MAGIC_COOKIE};
        end
    endtask

    task automatic take_attr_byte(input int unsigned off, input logic [7:0] b);
        bit          xored;
        int unsigned k;
        if (off == 0) begin
            p_attr_type = {b, 8'h00};
            p_attr_len  = '0;
        end else if (off == 1) begin
            p_attr_type[7:0] = b;
            if (is_addr_attr(p_attr_type)) begin
                xored   = is_xor_attr(p_attr_type);
                p_found = 1'b1;
                if (xored)
                    p_walk_done = 1'b1;
                p_v6   = 1'b1;
                p_port = xored ? PORT_KEY : 16'h0;
                load_address_key(xored, 1'b1);
            end
        end else if (off == 2) begin
            p_attr_len = {b, 8'h00};
        end else if (off == 3) begin
            p_attr_len[7:0] = b;
        end else if (is_addr_attr(p_attr_type) && off - 4 < 32'(p_attr_len)) begin
            xored = is_xor_attr(p_attr_type);
            if (off == 5) begin
                p_v6 = (b != FAMILY_V4);
                load_address_key(xored, p_v6);
            end else if (off == 6) begin
                p_port[15:8] = p_port[15:8] ^ b;
            end else if (off == 7) begin
                p_port[7:0] = p_port[7:0] ^ b;
            end else if (off >= 8 && off < 24) begin
                k = off - 8;
                if (!p_v6) begin
                    if (k < 4)
                        p_addr[1] = p_addr[1] ^ (64'(b) << (8 * (3 - k)));
                end else if (k < 8) begin
                    p_addr[0] = p_addr[0] ^ (64'(b) << (8 * (7 - k)));
                end else begin
                    p_addr[1] = p_addr[1] ^ (64'(b) << (8 * (15 - k)));
                end
            end
        end
    endtask

    task automatic parse_byte(input t_in_item it, output bit produced, output t_out_item res);
        int unsigned pos;
        int unsigned msg_end;
        int unsigned nxt;
        logic [7:0]  b;
        b       = it.data_byte;
        pos     = 32'(p_pos);
        msg_end = 32'(p_body_len) + 32'd20;
        if (pos == 0) begin
            p_type = {b, 8'h00};
        end else if (pos == 1) begin
            p_type[7:0] = b;
        end else if (pos == 2) begin
            p_body_len = {b, 8'h00};
        end else if (pos == 3) begin
            p_body_len[7:0] = b;
        end else if (pos < 12) begin
            p_hdr[0] = p_hdr[0] | (64'(b) << (8 * (11 - pos)));
        end else if (pos < 20) begin
            p_hdr[1] = p_hdr[1] | (64'(b) << (8 * (19 - pos)));
        end else if (pos < msg_end && pos >= 32'(p_attr_base)) begin
            // advance to the next attribute once the padded value is done
            if (!p_walk_done && pos - 32'(p_attr_base) >= 4) begin
                nxt = 32'(p_attr_base) + 4 + ((32'(p_attr_len) + 3) & ~32'd3);
                if (nxt > 32'(POS_MAX))
                    nxt = 32'(POS_MAX);
                if (pos == nxt)
                    p_attr_base = nxt[16:0];
            end
            take_attr_byte(pos - 32'(p_attr_base), b);
        end
        if (p_pos < POS_MAX)
            p_pos = p_pos + 17'd1;

        produced = it.end_of_datagram;
        res      = '0;
        if (produced) begin
            if (p_type != TYPE_BINDING_SUCCESS) begin
                res.status = STATUS_NOT_SUCCESS;
            end else if (!p_found) begin
                res.status = STATUS_NO_ADDRESS;
            end else begin
                res.status       = STATUS_FOUND;
                res.is_ipv6      = p_v6;
                res.mapped_port  = p_port;
                res.address_high = p_v6 ? p_addr[0] : 64'h0;
                res.address_low  = p_v6 ? p_addr[1] : {32'h0, p_addr[1][31:0]};
            end
            parser_clear();
        end
    endtask

    task automatic compare_result(input t_out_item want, input t_out_item got);
        bit bad;
        bad = 1'b0;
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            bad = 1'b1;
        end
        if (got.is_ipv6 !== want.is_ipv6) begin
            $error("is_ipv6: expected %0d, got %0d", want.is_ipv6, got.is_ipv6);
            bad = 1'b1;
        end
        if (got.mapped_port !== want.mapped_port) begin
            $error("mapped_port: expected %h, got %h", want.mapped_port, got.mapped_port);
            bad = 1'b1;
        end
        if (got.address_high !== want.address_high) begin
            $error("address_high: expected %h, got %h", want.address_high, got.address_high);
            bad = 1'b1;
        end
        if (got.address_low !== want.address_low) begin
            $error("address_low: expected %h, got %h", want.address_low, got.address_low);
            bad = 1'b1;
        end
        if (bad)
            bad_results++;
    endtask

    initial parser_clear();

    always @(posedge clk) begin : result_check
        bit        produced;
        t_out_item res;
        if (rst_n && in_valid && in_ready) begin
            parse_byte(in_data, produced, res);
            if (produced)
                due_results.push_back(row_typed ? row_want : res);
        end
        if (rst_n && out_valid && out_ready) begin
            if (due_results.size() == 0) begin
                $error("result transfer with no result due: status %0d", out_data.status);
                bad_results++;
            end else begin
                compare_result(due_results.pop_front(), out_data);
            end
        end
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                             input t_out_item want);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_data   <= '{data_byte: b, end_of_datagram: last};
        row_typed <= typed;
        row_want  <= want;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_datagram();
        int unsigned i;
        for (i = 0; i < dgram_q.size(); i++)
            send_byte(dgram_q[i], i == dgram_q.size() - 1, 1'b0, NO_WANT);
    endtask

    // hold the sender until every due result has been transferred
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic put_word(input logic [15:0] w);
        dgram_q.push_back(w[15:8]);
        dgram_q.push_back(w[7:0]);
    endtask

    task automatic put_random(input int unsigned n);
        repeat (n) dgram_q.push_back(8'($urandom));
    endtask

    task automatic build_response();
        logic [7:0]  body[$];
        logic [15:0] atype;
        logic [15:0] blen;
        logic [7:0]  fam;
        int unsigned n_attr;
        int unsigned alen;
        int unsigned cut;
        int unsigned i;
        int unsigned j;
        body   = {};
        n_attr = $urandom_range(3, 0);
        for (i = 0; i < n_attr; i++) begin
            case ($urandom_range(7, 0))
                0, 1, 2: atype = ATTR_MAPPED;
                3, 4:    atype = ATTR_XOR_MAPPED;
                5:       atype = ATTR_XOR_MAPPED_ALT;
                default: atype = 16'($urandom);
            endcase
            case ($urandom_range(9, 0))
                0, 1, 2, 3, 4, 5: fam = FAMILY_V4;
                6, 7, 8:          fam = 8'h02;
                default:          fam = 8'($urandom);
            endcase
            if (!is_addr_attr(atype))
                alen = $urandom_range(12, 0);
            else if ($urandom_range(3, 0) != 0)
                alen = (fam == FAMILY_V4) ? 8 : 20;
            else
                alen = $urandom_range(24, 0);
            body.push_back(atype[15:8]);
            body.push_back(atype[7:0]);
            body.push_back(8'(alen >> 8));
            body.push_back(8'(alen));
            for (j = 0; j < alen; j++)
                body.push_back((j == 1) ? fam : 8'($urandom));
            while (body.size() % 4 != 0)
                body.push_back(8'($urandom));
        end

        if ($urandom_range(7, 0) == 0)
            blen = 16'($urandom_range(body.size() + 8, 0));
        else
            blen = 16'(body.size());
        dgram_q = {};
        put_word(($urandom_range(7, 0) == 0) ? 16'($urandom) : TYPE_BINDING_SUCCESS);
        put_word(blen);
        if ($urandom_range(3, 0) != 0) begin
            put_word(MAGIC_COOKIE[31:16]);
            put_word(MAGIC_COOKIE[15:0]);
        end else begin
            put_random(4);
        end
        put_random(12);
        for (i = 0; i < body.size(); i++)
            dgram_q.push_back(body[i]);

        // trailing junk or a cut-short datagram now and then
        case ($urandom_range(7, 0))
            0: put_random($urandom_range(6, 1));
            1: begin
                cut = $urandom_range(dgram_q.size(), 1);
                while (dgram_q.size() > cut)
                    void'(dgram_q.pop_back());
            end
            default: ;
        endcase
    endtask

    task automatic build_noise();
        dgram_q = {};
        put_random($urandom_range(32, 1));
        if (dgram_q.size() >= 2 && $urandom_range(1, 0) == 1) begin
            dgram_q[0] = TYPE_BINDING_SUCCESS[15:8];
            dgram_q[1] = TYPE_BINDING_SUCCESS[7:0];
        end
    endtask

    initial begin : stimulus
        int unsigned r;
        int unsigned k;
        int unsigned phase;
        int unsigned n_bytes;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 31;
        recv_idle_pct = 75;
        for (r = 0; r < $size(DIRECTED); r++) begin
            for (k = 0; k < DIRECTED[r].count; k++)
                send_byte(DIRECTED[r].data, DIRECTED[r].last && k == DIRECTED[r].count - 1,
                          DIRECTED[r].last, DIRECTED[r].want);
        end
        drain_results();

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 31; recv_idle_pct = 75; end
                1: begin send_idle_pct = 75; recv_idle_pct = 31; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            n_bytes = 0;
            while (n_bytes < 230) begin
                if ($urandom_range(3, 0) != 0)
                    build_response();
                else
                    build_noise();
                send_datagram();
                n_bytes += dgram_q.size();
            end
            drain_results();
        end

        repeat (16) @(posedge clk);
        if (bad_results == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
